@@ src/bsrc_pkg.sv @@
// Package for the banker's safety and request check block.
// Holds op and status codes shared by the sequencer and the top level.
`default_nettype none
package bsrc_pkg;
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_LOAD_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_CLAIM = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_AVAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_REQ_ELEM   = 3'd3;
    localparam logic [OP_W-1:0] OP_SAFETY     = 3'd4;

    localparam logic [2:0] ST_SAFE         = 3'd0;
    localparam logic [2:0] ST_UNSAFE       = 3'd1;
    localparam logic [2:0] ST_GRANTED      = 3'd2;
    localparam logic [2:0] ST_EXCEEDS_NEED = 3'd3;
    localparam logic [2:0] ST_INSUFFICIENT = 3'd4;
    localparam logic [2:0] ST_UNSAFE_DENY  = 3'd5;

    localparam int WORK_W = 12;
    localparam logic [WORK_W-1:0] WORK_CAP = 12'hFFF;
endpackage
`default_nettype wire

@@ src/bsrc_cmp.sv @@
// Shared compare/add unit: one resource element at a time.
// Depends on bsrc_pkg for the work width.
`default_nettype none
module bsrc_cmp (
    input  wire logic [7:0]                   claim,
    input  wire logic [7:0]                   alloc,
    input  wire logic [7:0]                   rhs8,
    input  wire logic [bsrc_pkg::WORK_W-1:0]  work,
    output logic                              need_gt_work,
    output logic                              req_gt_need,
    output logic                              req_gt_avail,
    output logic [bsrc_pkg::WORK_W-1:0]       work_sum
);
    logic signed [9:0] need;
    logic [bsrc_pkg::WORK_W:0] sum;
    assign need = $signed({2'b00, claim}) - $signed({2'b00, alloc});
    assign need_gt_work = need > $signed({1'b0, work[8:0]}) && work[11:9] == 3'd0;
    assign req_gt_need  = $signed({2'b00, rhs8}) > need;
    assign req_gt_avail = rhs8 > work[7:0];
    assign sum = {1'b0, work} + {5'd0, alloc};
    assign work_sum = sum[bsrc_pkg::WORK_W] ? bsrc_pkg::WORK_CAP : sum[bsrc_pkg::WORK_W-1:0];
endmodule
`default_nettype wire

@@ src/bankers_safety_and_request_check.sv @@
// Top level: APB registers, tables, sequencer around bsrc_cmp.
// Depends on bsrc_pkg and bsrc_cmp.
//  channel  | dir | tdata (low bit up)                          | tuser/tlast
//  s_axis   | in  | op[2:0] proc_id[5:3] res_id[8:6] amount[16:9]| tlast=req_last
//  m_axis   | out | status[2:0] seq_proc[5:3] seq_pos[8:6]       | tlast=last
//  apb      | in  | reg 0 num_processes, reg 1 num_resources     |
// Tables have a registered read, so each table element is fetched and then used.
// A request checks each element against need, then against avail, then writes
// the tentative allocation, then a safety check: up to n passes over n processes,
// each candidate's need compared to work and its alloc added if it fits;
// rollback restores m elements. For a safety op, a safe sequence then streams
// n words. Stalls on m_axis hold the sequencer. Reset is synchronous.
`default_nettype none
module bankers_safety_and_request_check #(
    parameter int MAX_PROCS     = 8,
    parameter int MAX_RES_TYPES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // op, proc_id, res_id, amount
    input  wire logic        s_axis_tlast,  // req_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // status, seq_proc, seq_pos
    output logic             m_axis_tlast,  // last
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RW = (MAX_RES_TYPES > 1) ? $clog2(MAX_RES_TYPES) : 1;
    localparam int DEPTH = MAX_PROCS * MAX_RES_TYPES;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW = bsrc_pkg::WORK_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RQ_NEED, S_RQ_AVAIL, S_RQ_APPLY, S_SF_INIT, S_SF_CMP,
        S_SF_ADD, S_SF_NEXT, S_RQ_BACK, S_OUT_ONE, S_OUT_SEQ
    } state_t;

    state_t state_reg;
    logic [3:0] np_reg, nr_reg;
    logic [7:0] alloc_mem [DEPTH];
    logic [7:0] claim_mem [DEPTH];
    logic [7:0] avail_reg [MAX_RES_TYPES];
    logic [7:0] req_reg [MAX_RES_TYPES];
    logic [7:0] save_reg [MAX_RES_TYPES];
    logic [WW-1:0] work_reg [MAX_RES_TYPES];
    logic [MAX_PROCS-1:0] fin_reg;
    logic [2:0] seq_reg [MAX_PROCS];
    logic [PW-1:0] p_reg, pid_reg;
    logic [RW-1:0] r_reg;
    logic [3:0] cnt_reg, opos_reg;
    logic found_reg, is_req_reg, ph_reg;
    logic [2:0] st_reg;

    logic [3:0] n_eff, m_eff;
    assign n_eff = (np_reg == 4'd0) ? 4'd1 :
                   (32'(np_reg) > MAX_PROCS) ? 4'(MAX_PROCS) : np_reg;
    assign m_eff = (nr_reg == 4'd0) ? 4'd1 :
                   (32'(nr_reg) > MAX_RES_TYPES) ? 4'(MAX_RES_TYPES) : nr_reg;

    logic [2:0] in_op, in_p, in_r;
    logic [7:0] in_amt;
    assign in_op = s_axis_tdata[2:0];
    assign in_p = s_axis_tdata[5:3];
    assign in_r = s_axis_tdata[8:6];
    assign in_amt = s_axis_tdata[16:9];
    logic pin, rin;
    assign pin = 32'(in_p) < MAX_PROCS;
    assign rin = 32'(in_r) < MAX_RES_TYPES;
    logic [AW-1:0] in_addr;
    assign in_addr = AW'(32'(in_p) * MAX_RES_TYPES + 32'(in_r));

    logic [PW-1:0] cur_p;
    assign cur_p = (state_reg == S_SF_CMP || state_reg == S_SF_ADD) ? p_reg : pid_reg;
    logic [AW-1:0] addr;
    assign addr = AW'(32'(cur_p) * MAX_RES_TYPES + 32'(r_reg));
    logic [7:0] a_rd_reg, c_rd_reg;

    always_ff @(posedge aclk) begin
        a_rd_reg <= alloc_mem[addr];
        c_rd_reg <= claim_mem[addr];
    end

    logic ngw, rgn, rga;
    logic [WW-1:0] wsum, cmp_work;
    logic [7:0] rhs8;
    assign rhs8 = req_reg[r_reg];
    assign cmp_work = (state_reg == S_RQ_AVAIL) ? {4'd0, avail_reg[r_reg]} : work_reg[r_reg];
    bsrc_cmp u_cmp (
        .claim(c_rd_reg), .alloc(a_rd_reg), .rhs8(rhs8), .work(cmp_work),
        .need_gt_work(ngw), .req_gt_need(rgn), .req_gt_avail(rga), .work_sum(wsum)
    );

    logic r_end, p_end;
    assign r_end = 4'(r_reg) + 4'd1 >= m_eff;
    assign p_end = 4'(p_reg) + 4'd1 >= n_eff;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, np_reg} : {28'd0, nr_reg};
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT_ONE) || (state_reg == S_OUT_SEQ);
    assign m_axis_tdata = (state_reg == S_OUT_SEQ) ?
        {7'd0, opos_reg[2:0], seq_reg[opos_reg[PW-1:0]], bsrc_pkg::ST_SAFE} :
        {13'd0, st_reg};
    assign m_axis_tlast = (state_reg == S_OUT_ONE) || (opos_reg + 4'd1 == n_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            np_reg <= 4'd8;
            nr_reg <= 4'd8;
            fin_reg <= '0;
            ph_reg <= 1'b0;
            for (int i = 0; i < MAX_RES_TYPES; i++) work_reg[i] <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == 3'd0) np_reg <= pwdata[3:0];
                else if (paddr == 3'd4) nr_reg <= pwdata[3:0];
            end
            case (state_reg)
                S_IDLE: if (s_axis_tvalid) begin
                    r_reg <= '0;
                    pid_reg <= in_p[PW-1:0];
                    case (in_op)
                        bsrc_pkg::OP_LOAD_ALLOC:
                            if (pin && rin) alloc_mem[in_addr] <= in_amt;
                        bsrc_pkg::OP_LOAD_CLAIM:
                            if (pin && rin) claim_mem[in_addr] <= in_amt;
                        bsrc_pkg::OP_LOAD_AVAIL:
                            if (rin) avail_reg[in_r[RW-1:0]] <= in_amt;
                        bsrc_pkg::OP_REQ_ELEM: begin
                            if (rin) req_reg[in_r[RW-1:0]] <= in_amt;
                            if (s_axis_tlast) begin
                                is_req_reg <= 1'b1;
                                if (!pin) begin
                                    st_reg <= bsrc_pkg::ST_EXCEEDS_NEED;
                                    state_reg <= S_OUT_ONE;
                                end else state_reg <= S_RQ_NEED;
                            end
                        end
                        bsrc_pkg::OP_SAFETY: begin
                            is_req_reg <= 1'b0;
                            state_reg <= S_SF_INIT;
                        end
                        default: ;
                    endcase
                end
                S_RQ_NEED: begin
                    if (!ph_reg) ph_reg <= 1'b1;
                    else begin
                        ph_reg <= 1'b0;
                        if (rgn) begin
                            st_reg <= bsrc_pkg::ST_EXCEEDS_NEED;
                            state_reg <= S_OUT_ONE;
                        end else if (r_end) begin
                            r_reg <= '0;
                            state_reg <= S_RQ_AVAIL;
                        end else r_reg <= r_reg + 1'b1;
                    end
                end
                S_RQ_AVAIL: begin
                    if (rga) begin
                        st_reg <= bsrc_pkg::ST_INSUFFICIENT;
                        state_reg <= S_OUT_ONE;
                    end else if (r_end) begin
                        r_reg <= '0;
                        state_reg <= S_RQ_APPLY;
                    end else r_reg <= r_reg + 1'b1;
                end
                S_RQ_APPLY: begin
                    if (!ph_reg) ph_reg <= 1'b1;
                    else begin
                        ph_reg <= 1'b0;
                        save_reg[r_reg] <= a_rd_reg;
                        alloc_mem[addr] <= a_rd_reg + rhs8;
                        avail_reg[r_reg] <= avail_reg[r_reg] - rhs8;
                        if (r_end) state_reg <= S_SF_INIT;
                        else r_reg <= r_reg + 1'b1;
                    end
                end
                S_SF_INIT: begin
                    for (int i = 0; i < MAX_RES_TYPES; i++)
                        work_reg[i] <= (i < 32'(m_eff)) ? {4'd0, avail_reg[i]} : '0;
                    fin_reg <= '0;
                    p_reg <= '0;
                    r_reg <= '0;
                    cnt_reg <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_SF_NEXT;
                end
                S_SF_NEXT: begin
                    // p_reg names the candidate; skip finished processes
                    if (cnt_reg == n_eff) begin
                        if (is_req_reg) begin
                            st_reg <= bsrc_pkg::ST_GRANTED;
                            state_reg <= S_OUT_ONE;
                        end else begin
                            opos_reg <= '0;
                            state_reg <= S_OUT_SEQ;
                        end
                    end else if (fin_reg[p_reg]) begin
                        if (p_end) begin
                            if (!found_reg) begin
                                r_reg <= '0;
                                state_reg <= S_RQ_BACK;
                            end
                            p_reg <= '0;
                            found_reg <= 1'b0;
                        end else p_reg <= p_reg + 1'b1;
                    end else begin
                        r_reg <= '0;
                        state_reg <= S_SF_CMP;
                    end
                end
                S_SF_CMP: begin
                    if (!ph_reg) ph_reg <= 1'b1;
                    else begin
                        ph_reg <= 1'b0;
                        if (ngw) begin
                            if (p_end) begin
                                if (!found_reg) state_reg <= S_RQ_BACK;
                                else state_reg <= S_SF_NEXT;
                                r_reg <= '0;
                                p_reg <= '0;
                                found_reg <= 1'b0;
                            end else begin
                                state_reg <= S_SF_NEXT;
                                p_reg <= p_reg + 1'b1;
                            end
                        end else if (r_end) begin
                            r_reg <= '0;
                            state_reg <= S_SF_ADD;
                        end else r_reg <= r_reg + 1'b1;
                    end
                end
                S_SF_ADD: begin
                    if (!ph_reg) ph_reg <= 1'b1;
                    else begin
                        ph_reg <= 1'b0;
                        work_reg[r_reg] <= wsum;
                        if (r_end) begin
                            fin_reg[p_reg] <= 1'b1;
                            seq_reg[cnt_reg[PW-1:0]] <= 3'(p_reg);
                            cnt_reg <= cnt_reg + 4'd1;
                            state_reg <= S_SF_NEXT;
                            if (p_end) begin
                                p_reg <= '0;
                                found_reg <= 1'b0;
                            end else begin
                                p_reg <= p_reg + 1'b1;
                                found_reg <= 1'b1;
                            end
                        end else r_reg <= r_reg + 1'b1;
                    end
                end
                S_RQ_BACK: begin
                    if (!is_req_reg) begin
                        st_reg <= bsrc_pkg::ST_UNSAFE;
                        state_reg <= S_OUT_ONE;
                    end else begin
                        alloc_mem[addr] <= save_reg[r_reg];
                        avail_reg[r_reg] <= avail_reg[r_reg] + rhs8;
                        if (r_end) begin
                            st_reg <= bsrc_pkg::ST_UNSAFE_DENY;
                            state_reg <= S_OUT_ONE;
                        end else r_reg <= r_reg + 1'b1;
                    end
                end
                S_OUT_ONE: if (m_axis_tready) state_reg <= S_IDLE;
                S_OUT_SEQ: if (m_axis_tready) begin
                    if (opos_reg + 4'd1 == n_eff) state_reg <= S_IDLE;
                    opos_reg <= opos_reg + 4'd1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/bsrc_checker.sv @@
// Port-level checker for the banker's block, bound to the top level.
// Depends on bankers_safety_and_request_check ports only.
`default_nettype none
module bsrc_props (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while output pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tlast &&
        m_axis_tdata[8:3] == 6'd0) else $error("bad status word");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output after reset");
endmodule

bind bankers_safety_and_request_check bsrc_props u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
